### design/sha512_pkg.sv
`timescale 1ns / 1ps

package sha512_pkg;

    localparam int WORD_W  = 64;
    localparam int COUNT_W = 4;
    localparam int BUF_DEPTH = 16;
    localparam int HASH_WORDS = 8;
    localparam int ROUNDS = 80;
    localparam int RND_W = 7;
    localparam int FILL_W = 4;
    localparam int IDX_W = 3;
    localparam int TDATA_W = 72;

    localparam logic [RND_W-1:0] LAST_RND = RND_W'(ROUNDS - 1);
    localparam logic [FILL_W-1:0] FILL_LEN_HI = FILL_W'(BUF_DEPTH - 2);
    localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(BUF_DEPTH - 1);
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(HASH_WORDS - 1);
    localparam logic [WORD_W-1:0] PAD_WORD = 64'h8000_0000_0000_0000;

    // Source of the word shifted into the block buffer
    typedef enum logic [2:0] {
        SEL_INPUT  = 3'd0,
        SEL_TAIL   = 3'd1,
        SEL_PAD80  = 3'd2,
        SEL_ZERO   = 3'd3,
        SEL_LEN_HI = 3'd4,
        SEL_LEN_LO = 3'd5
    } push_sel_t;

    typedef struct packed {
        logic             push;
        push_sel_t        sel;
        logic             add_bytes;
        logic             load_work;
        logic             round;
        logic [RND_W-1:0] rnd;
        logic             fold;
        logic             out_shift;
        logic [IDX_W-1:0] out_idx;
        logic             clear_total;
    } dp_cmd_t;

    localparam logic [WORD_W-1:0] IV_TABLE [HASH_WORDS] = '{
        64'h6a09e667f3bcc908, 64'hbb67ae8584caa73b,
        64'h3c6ef372fe94f82b, 64'ha54ff53a5f1d36f1,
        64'h510e527fade682d1, 64'h9b05688c2b3e6c1f,
        64'h1f83d9abfb41bd6b, 64'h5be0cd19137e2179
    };

    localparam logic [WORD_W-1:0] K_TABLE [ROUNDS] = '{
        64'h428a2f98d728ae22, 64'h7137449123ef65cd, 64'hb5c0fbcfec4d3b2f, 64'he9b5dba58189dbbc,
        64'h3956c25bf348b538, 64'h59f111f1b605d019, 64'h923f82a4af194f9b, 64'hab1c5ed5da6d8118,
        64'hd807aa98a3030242, 64'h12835b0145706fbe, 64'h243185be4ee4b28c, 64'h550c7dc3d5ffb4e2,
        64'h72be5d74f27b896f, 64'h80deb1fe3b1696b1, 64'h9bdc06a725c71235, 64'hc19bf174cf692694,
        64'he49b69c19ef14ad2, 64'hefbe4786384f25e3, 64'h0fc19dc68b8cd5b5, 64'h240ca1cc77ac9c65,
        64'h2de92c6f592b0275, 64'h4a7484aa6ea6e483, 64'h5cb0a9dcbd41fbd4, 64'h76f988da831153b5,
        64'h983e5152ee66dfab, 64'ha831c66d2db43210, 64'hb00327c898fb213f, 64'hbf597fc7beef0ee4,
        64'hc6e00bf33da88fc2, 64'hd5a79147930aa725, 64'h06ca6351e003826f, 64'h142929670a0e6e70,
        64'h27b70a8546d22ffc, 64'h2e1b21385c26c926, 64'h4d2c6dfc5ac42aed, 64'h53380d139d95b3df,
        64'h650a73548baf63de, 64'h766a0abb3c77b2a8, 64'h81c2c92e47edaee6, 64'h92722c851482353b,
        64'ha2bfe8a14cf10364, 64'ha81a664bbc423001, 64'hc24b8b70d0f89791, 64'hc76c51a30654be30,
        64'hd192e819d6ef5218, 64'hd69906245565a910, 64'hf40e35855771202a, 64'h106aa07032bbd1b8,
        64'h19a4c116b8d2d0c8, 64'h1e376c085141ab53, 64'h2748774cdf8eeb99, 64'h34b0bcb5e19b48a8,
        64'h391c0cb3c5c95a63, 64'h4ed8aa4ae3418acb, 64'h5b9cca4f7763e373, 64'h682e6ff3d6b2b8a3,
        64'h748f82ee5defb2fc, 64'h78a5636f43172f60, 64'h84c87814a1f0ab72, 64'h8cc702081a6439ec,
        64'h90befffa23631e28, 64'ha4506cebde82bde9, 64'hbef9a3f7b2c67915, 64'hc67178f2e372532b,
        64'hca273eceea26619c, 64'hd186b8c721c0c207, 64'heada7dd6cde0eb1e, 64'hf57d4f7fee6ed178,
        64'h06f067aa72176fba, 64'h0a637dc5a2c898a6, 64'h113f9804bef90dae, 64'h1b710b35131c471b,
        64'h28db77f523047d84, 64'h32caab7b40c72493, 64'h3c9ebe0a15c9bebc, 64'h431d67c49c100d4c,
        64'h4cc5d4becb3e42b6, 64'h597f299cfc657e2a, 64'h5fcb6fab3ad6faec, 64'h6c44198c4a475817
    };

endpackage

### design/sha512_ctrl.sv
`timescale 1ns / 1ps

module sha512_ctrl
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic                      in_final,
    input  logic [3:0]                in_count,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic                      out_last,
    output logic [2:0]                out_idx,
    output sha512_pkg::dp_cmd_t       cmd
);
    import sha512_pkg::*;

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_PAD   = 5'b00010,
        ST_ROUND = 5'b00100,
        ST_FOLD  = 5'b01000,
        ST_OUT   = 5'b10000
    } state_t;

    state_t             state_reg, state_next;
    logic [FILL_W-1:0]  fill_reg, fill_next;
    logic [RND_W-1:0]   rnd_reg, rnd_next;
    logic [IDX_W-1:0]   idx_reg, idx_next;
    logic               pad_active_reg, pad_active_next;
    logic               pad80_reg, pad80_next;
    logic               hi_done_reg, hi_done_next;
    logic               last_block_reg, last_block_next;
    logic               full_count;
    logic               wrap;

    // counts of eight and above take the whole word
    assign full_count = in_count[3];
    // a push in this cycle completes the block
    assign wrap = (fill_reg == FILL_FULL);

    always_comb
    begin
        state_next      = state_reg;
        fill_next       = fill_reg;
        rnd_next        = rnd_reg;
        idx_next        = idx_reg;
        pad_active_next = pad_active_reg;
        pad80_next      = pad80_reg;
        hi_done_next    = hi_done_reg;
        last_block_next = last_block_reg;

        cmd             = '0;
        cmd.sel         = SEL_INPUT;
        cmd.rnd         = rnd_reg;
        cmd.out_idx     = idx_reg;
        in_ready        = 1'b0;
        out_valid       = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.push      = 1'b1;
                    cmd.add_bytes = 1'b1;
                    if (in_final)
                    begin
                        pad_active_next = 1'b1;
                        pad80_next      = full_count;
                        cmd.sel         = full_count ? SEL_INPUT : SEL_TAIL;
                    end
                    if (wrap)
                    begin
                        cmd.load_work = 1'b1;
                        state_next    = ST_ROUND;
                    end
                    else if (in_final)
                    begin
                        state_next = ST_PAD;
                    end
                end
            end
            ST_PAD:
            begin
                cmd.push = 1'b1;
                priority if (pad80_reg)
                begin
                    cmd.sel    = SEL_PAD80;
                    pad80_next = 1'b0;
                end
                else if (hi_done_reg)
                begin
                    cmd.sel         = SEL_LEN_LO;
                    hi_done_next    = 1'b0;
                    last_block_next = 1'b1;
                end
                else if (fill_reg == FILL_LEN_HI)
                begin
                    cmd.sel      = SEL_LEN_HI;
                    hi_done_next = 1'b1;
                end
                else
                begin
                    cmd.sel = SEL_ZERO;
                end
                if (wrap)
                begin
                    cmd.load_work = 1'b1;
                    state_next    = ST_ROUND;
                end
            end
            ST_ROUND:
            begin
                cmd.round = 1'b1;
                if (rnd_reg == LAST_RND)
                begin
                    rnd_next   = '0;
                    state_next = ST_FOLD;
                end
                else
                begin
                    rnd_next = rnd_reg + 1'b1;
                end
            end
            ST_FOLD:
            begin
                cmd.fold = 1'b1;
                priority if (last_block_reg)
                    state_next = ST_OUT;
                else if (pad_active_reg)
                    state_next = ST_PAD;
                else
                    state_next = ST_IDLE;
            end
            ST_OUT:
            begin
                out_valid = 1'b1;
                if (out_ready)
                begin
                    cmd.out_shift = 1'b1;
                    idx_next      = idx_reg + 1'b1;
                    if (idx_reg == IDX_LAST)
                    begin
                        cmd.clear_total = 1'b1;
                        pad_active_next = 1'b0;
                        last_block_next = 1'b0;
                        state_next      = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (cmd.push)
            fill_next = fill_reg + 1'b1;
    end

    assign out_last = (idx_reg == IDX_LAST);
    assign out_idx  = idx_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            fill_reg       <= '0;
            rnd_reg        <= '0;
            idx_reg        <= '0;
            pad_active_reg <= 1'b0;
            pad80_reg      <= 1'b0;
            hi_done_reg    <= 1'b0;
            last_block_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            fill_reg       <= fill_next;
            rnd_reg        <= rnd_next;
            idx_reg        <= idx_next;
            pad_active_reg <= pad_active_next;
            pad80_reg      <= pad80_next;
            hi_done_reg    <= hi_done_next;
            last_block_reg <= last_block_next;
        end
    end

endmodule

### design/sha512_dp.sv
`timescale 1ns / 1ps

module sha512_dp
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  sha512_pkg::dp_cmd_t       cmd,
    input  logic [63:0]               in_word,
    input  logic [3:0]                in_count,
    output logic [63:0]               digest_word
);
    import sha512_pkg::*;

    logic [WORD_W-1:0] buf_reg [BUF_DEPTH];
    logic [WORD_W-1:0] hash_reg [HASH_WORDS];
    logic [WORD_W-1:0] work_reg [HASH_WORDS];
    logic [WORD_W-1:0] total_reg;

    logic [WORD_W-1:0] push_word;
    logic [WORD_W-1:0] tail_word;
    logic [3:0]        count_c;
    logic [WORD_W-1:0] sched_word;
    logic [WORD_W-1:0] sig0, sig1;
    logic [WORD_W-1:0] big0, big1, choose, major, t1, t2;
    logic [WORD_W-1:0] a, b, c, d, e, f, g, h;

    assign count_c = in_count[3] ? 4'd8 : in_count;

    // keep the leading bytes, put the pad byte right after them, clear the rest
    always_comb
    begin
        for (int j = 0; j < 8; j++)
        begin
            if (4'(j) < count_c)
                tail_word[63-8*j -: 8] = in_word[63-8*j -: 8];
            else if (4'(j) == count_c)
                tail_word[63-8*j -: 8] = 8'h80;
            else
                tail_word[63-8*j -: 8] = 8'h00;
        end
    end

    always_comb
    begin
        unique case (cmd.sel)
            SEL_INPUT:  push_word = in_word;
            SEL_TAIL:   push_word = tail_word;
            SEL_PAD80:  push_word = PAD_WORD;
            SEL_ZERO:   push_word = '0;
            SEL_LEN_HI: push_word = {61'b0, total_reg[63:61]};
            SEL_LEN_LO: push_word = {total_reg[60:0], 3'b000};
            default:    push_word = '0;
        endcase
    end

    // message schedule: the buffer head is w[t]
    assign sig0 = {buf_reg[1][0], buf_reg[1][63:1]} ^ {buf_reg[1][7:0], buf_reg[1][63:8]}
                ^ (buf_reg[1] >> 7);
    assign sig1 = {buf_reg[14][18:0], buf_reg[14][63:19]}
                ^ {buf_reg[14][60:0], buf_reg[14][63:61]} ^ (buf_reg[14] >> 6);
    assign sched_word = sig1 + buf_reg[9] + sig0 + buf_reg[0];

    assign a = work_reg[0];
    assign b = work_reg[1];
    assign c = work_reg[2];
    assign d = work_reg[3];
    assign e = work_reg[4];
    assign f = work_reg[5];
    assign g = work_reg[6];
    assign h = work_reg[7];

    assign big1   = {e[13:0], e[63:14]} ^ {e[17:0], e[63:18]} ^ {e[40:0], e[63:41]};
    assign choose = (e & f) ^ (~e & g);
    assign big0   = {a[27:0], a[63:28]} ^ {a[33:0], a[63:34]} ^ {a[38:0], a[63:39]};
    assign major  = (a & b) ^ (a & c) ^ (b & c);
    assign t1     = h + big1 + choose + K_TABLE[cmd.rnd] + buf_reg[0];
    assign t2     = big0 + major;

    assign digest_word = hash_reg[0];

    always_ff @(posedge clk)
    begin
        if (cmd.push || cmd.round)
        begin
            for (int i = 0; i < BUF_DEPTH - 1; i++)
                buf_reg[i] <= buf_reg[i+1];
            buf_reg[BUF_DEPTH-1] <= cmd.push ? push_word : sched_word;
        end

        if (cmd.load_work)
        begin
            for (int i = 0; i < HASH_WORDS; i++)
                work_reg[i] <= hash_reg[i];
        end
        else if (cmd.round)
        begin
            work_reg[0] <= t1 + t2;
            work_reg[1] <= a;
            work_reg[2] <= b;
            work_reg[3] <= c;
            work_reg[4] <= d + t1;
            work_reg[5] <= e;
            work_reg[6] <= f;
            work_reg[7] <= g;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < HASH_WORDS; i++)
                hash_reg[i] <= IV_TABLE[i];
            total_reg <= '0;
        end
        else
        begin
            if (cmd.fold)
            begin
                for (int i = 0; i < HASH_WORDS; i++)
                    hash_reg[i] <= hash_reg[i] + work_reg[i];
            end
            else if (cmd.out_shift)
            begin
                // drain word by word and refill with the initial values behind
                for (int i = 0; i < HASH_WORDS - 1; i++)
                    hash_reg[i] <= hash_reg[i+1];
                hash_reg[HASH_WORDS-1] <= IV_TABLE[cmd.out_idx];
            end

            // only a short final word adds its count; every other word adds eight
            if (cmd.clear_total)
                total_reg <= '0;
            else if (cmd.add_bytes)
                total_reg <= total_reg + ((cmd.sel == SEL_TAIL) ? 64'(count_c) : 64'd8);
        end
    end

endmodule

### design/sha512_hash.sv
`timescale 1ns / 1ps

// SHA-512 stream hasher. Send a message as 64-bit big-endian words on the
// slave side; mark the final word with s_tlast and give its count of valid
// leading bytes (0 to 8, larger counts read as 8; the count is ignored on
// other words, which always carry eight bytes). The block pads the message,
// appends the 128-bit bit length and then presents the eight digest words on
// the master side, word 0 first, with m_tlast on the eighth. Timing: every
// sixteenth word starts a compression of 80 rounds, one round per cycle,
// after which the result is folded into the chaining value; no word is
// taken while a block is compressed. After the final word the padding
// words go in at one per cycle, pausing while a full block is compressed;
// one or two blocks are compressed in all, and the digest drains at one
// transaction per cycle while the master side is ready. No new word is
// accepted from the final word until the last digest transaction; the next
// word then opens a new message.
module sha512_hash
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,   // [63:0] msg_word, [67:64] valid_bytes, [71:68] zero
    input  logic        s_tlast,   // final_item
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,   // [63:0] digest_word, [66:64] word_index, [71:67] zero
    output logic        m_tlast    // last_word
);
    import sha512_pkg::*;

    dp_cmd_t           cmd;
    logic [IDX_W-1:0]  out_idx;
    logic [WORD_W-1:0] digest_word;
    logic              out_last;

    // sequencer: word counting, padding order, rounds and digest drain
    sha512_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_final  (s_tlast),
        .in_count  (s_tdata[67:64]),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_last  (out_last),
        .out_idx   (out_idx),
        .cmd       (cmd)
    );

    // block buffer, schedule, round logic, chaining value and byte count
    sha512_dp u_dp
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .in_word     (s_tdata[63:0]),
        .in_count    (s_tdata[67:64]),
        .digest_word (digest_word)
    );

    // hold the digest word and its index straight from registers
    assign m_tdata = {5'b0, out_idx, digest_word};
    assign m_tlast = out_last;

endmodule

### tb/sv/sha512_hash_check.sv
`timescale 1ns / 1ps

module sha512_hash_check
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    input  logic                          s_tready,
    input  logic [sha512_pkg::TDATA_W-1:0] s_tdata,
    input  logic                          s_tlast,
    input  logic                          m_tvalid,
    input  logic                          m_tready,
    input  logic [sha512_pkg::TDATA_W-1:0] m_tdata,
    input  logic                          m_tlast,
    output int                            fail_count,
    output int                            pending,
    output int                            words_checked,
    output int                            msgs_closed
);
    import sha512_pkg::*;

    localparam int MAX_SHOWN = 10;

    localparam logic [63:0] ROUND_K [80] = '{
        64'h428a2f98d728ae22, 64'h7137449123ef65cd, 64'hb5c0fbcfec4d3b2f, 64'he9b5dba58189dbbc,
        64'h3956c25bf348b538, 64'h59f111f1b605d019, 64'h923f82a4af194f9b, 64'hab1c5ed5da6d8118,
        64'hd807aa98a3030242, 64'h12835b0145706fbe, 64'h243185be4ee4b28c, 64'h550c7dc3d5ffb4e2,
        64'h72be5d74f27b896f, 64'h80deb1fe3b1696b1, 64'h9bdc06a725c71235, 64'hc19bf174cf692694,
        64'he49b69c19ef14ad2, 64'hefbe4786384f25e3, 64'h0fc19dc68b8cd5b5, 64'h240ca1cc77ac9c65,
        64'h2de92c6f592b0275, 64'h4a7484aa6ea6e483, 64'h5cb0a9dcbd41fbd4, 64'h76f988da831153b5,
        64'h983e5152ee66dfab, 64'ha831c66d2db43210, 64'hb00327c898fb213f, 64'hbf597fc7beef0ee4,
        64'hc6e00bf33da88fc2, 64'hd5a79147930aa725, 64'h06ca6351e003826f, 64'h142929670a0e6e70,
        64'h27b70a8546d22ffc, 64'h2e1b21385c26c926, 64'h4d2c6dfc5ac42aed, 64'h53380d139d95b3df,
        64'h650a73548baf63de, 64'h766a0abb3c77b2a8, 64'h81c2c92e47edaee6, 64'h92722c851482353b,
        64'ha2bfe8a14cf10364, 64'ha81a664bbc423001, 64'hc24b8b70d0f89791, 64'hc76c51a30654be30,
        64'hd192e819d6ef5218, 64'hd69906245565a910, 64'hf40e35855771202a, 64'h106aa07032bbd1b8,
        64'h19a4c116b8d2d0c8, 64'h1e376c085141ab53, 64'h2748774cdf8eeb99, 64'h34b0bcb5e19b48a8,
        64'h391c0cb3c5c95a63, 64'h4ed8aa4ae3418acb, 64'h5b9cca4f7763e373, 64'h682e6ff3d6b2b8a3,
        64'h748f82ee5defb2fc, 64'h78a5636f43172f60, 64'h84c87814a1f0ab72, 64'h8cc702081a6439ec,
        64'h90befffa23631e28, 64'ha4506cebde82bde9, 64'hbef9a3f7b2c67915, 64'hc67178f2e372532b,
        64'hca273eceea26619c, 64'hd186b8c721c0c207, 64'heada7dd6cde0eb1e, 64'hf57d4f7fee6ed178,
        64'h06f067aa72176fba, 64'h0a637dc5a2c898a6, 64'h113f9804bef90dae, 64'h1b710b35131c471b,
        64'h28db77f523047d84, 64'h32caab7b40c72493, 64'h3c9ebe0a15c9bebc, 64'h431d67c49c100d4c,
        64'h4cc5d4becb3e42b6, 64'h597f299cfc657e2a, 64'h5fcb6fab3ad6faec, 64'h6c44198c4a475817
    };

    localparam logic [63:0] START_HASH [8] = '{
        64'h6a09e667f3bcc908, 64'hbb67ae8584caa73b,
        64'h3c6ef372fe94f82b, 64'ha54ff53a5f1d36f1,
        64'h510e527fade682d1, 64'h9b05688c2b3e6c1f,
        64'h1f83d9abfb41bd6b, 64'h5be0cd19137e2179
    };

    localparam logic [63:0] PAD_MARK = 64'h8000_0000_0000_0000;
    localparam logic [3:0]  LEN_SLOT = 4'd14;

    typedef struct packed {
        logic [63:0] digest;
        logic [2:0]  idx;
        logic        last;
    } digest_item_t;

    logic [63:0]  hash_state [8];
    logic [63:0]  word_buf [16];
    logic [3:0]   buf_fill;
    logic [63:0]  msg_bytes;
    digest_item_t digest_q [$];

    function automatic logic [63:0] ror64(input logic [63:0] x, input int n);
        return (x >> n) | (x << (64 - n));
    endfunction

    task automatic restart_message();
        for (int k = 0; k < 8; k++)
        begin
            hash_state[k] = START_HASH[k];
        end
        buf_fill  = '0;
        msg_bytes = '0;
    endtask

    task automatic compress_buffer();
        logic [63:0] w [80];
        logic [63:0] v [8];
        logic [63:0] s0, s1, sig0, sig1, ch, maj, t1, t2;
        for (int i = 0; i < 16; i++)
        begin
            w[i] = word_buf[i];
        end
        for (int i = 16; i < 80; i++)
        begin
            s0 = ror64(w[i-15], 1) ^ ror64(w[i-15], 8) ^ (w[i-15] >> 7);
            s1 = ror64(w[i-2], 19) ^ ror64(w[i-2], 61) ^ (w[i-2] >> 6);
            w[i] = s1 + w[i-7] + s0 + w[i-16];
        end
        for (int i = 0; i < 8; i++)
        begin
            v[i] = hash_state[i];
        end
        for (int i = 0; i < 80; i++)
        begin
            sig1 = ror64(v[4], 14) ^ ror64(v[4], 18) ^ ror64(v[4], 41);
            ch   = (v[4] & v[5]) ^ (~v[4] & v[6]);
            sig0 = ror64(v[0], 28) ^ ror64(v[0], 34) ^ ror64(v[0], 39);
            maj  = (v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]);
            t1   = v[7] + sig1 + ch + ROUND_K[i] + w[i];
            t2   = sig0 + maj;
            v[7] = v[6];
            v[6] = v[5];
            v[5] = v[4];
            v[4] = v[3] + t1;
            v[3] = v[2];
            v[2] = v[1];
            v[1] = v[0];
            v[0] = t1 + t2;
        end
        for (int i = 0; i < 8; i++)
        begin
            hash_state[i] = hash_state[i] + v[i];
        end
    endtask

    task automatic absorb_word(input logic [63:0] wd);
        word_buf[buf_fill] = wd;
        buf_fill = buf_fill + 4'd1;
        if (buf_fill == 4'd0)
            compress_buffer();
    endtask

    // Fold one accepted message word in; on the final word pad, append the
    // bit length and queue the eight digest words.
    task automatic take_item(input logic [63:0] wd, input logic [3:0] cnt, input logic fin);
        int unsigned  nb;
        logic [63:0]  keep;
        digest_item_t item;
        nb = (cnt > 4'd8) ? 8 : int'(cnt);
        if (!fin)
        begin
            absorb_word(wd);
            msg_bytes = msg_bytes + 64'd8;
        end
        else
        begin
            msg_bytes = msg_bytes + 64'(nb);
            if (nb == 8)
            begin
                absorb_word(wd);
                absorb_word(PAD_MARK);
            end
            else
            begin
                keep = (nb == 0) ? 64'd0 : (~64'd0 << (64 - 8 * nb));
                absorb_word((wd & keep) | (64'h80 << (56 - 8 * nb)));
            end
            while (buf_fill != LEN_SLOT)
                absorb_word(64'd0);
            absorb_word(msg_bytes >> 61);
            absorb_word(msg_bytes << 3);
            for (int k = 0; k < 8; k++)
            begin
                item.digest = hash_state[k];
                item.idx    = 3'(k);
                item.last   = (k == 7);
                digest_q.push_back(item);
            end
            msgs_closed++;
            restart_message();
        end
    endtask

    task automatic flag_mismatch(input string what, input logic [63:0] want,
                                 input logic [63:0] got);
        fail_count++;
        if (fail_count <= MAX_SHOWN)
            $display("%0t ns: %0s: expected %h, got %h", $time, what, want, got);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        digest_item_t want;
        if (!rst_n)
        begin
            restart_message();
            digest_q.delete();
            fail_count    = 0;
            words_checked = 0;
            msgs_closed   = 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                take_item(s_tdata[63:0], s_tdata[67:64], s_tlast);
            if (m_tvalid && m_tready)
            begin
                if (digest_q.size() == 0)
                begin
                    flag_mismatch("digest word with nothing outstanding", 64'd0, m_tdata[63:0]);
                end
                else
                begin
                    want = digest_q.pop_front();
                    words_checked++;
                    if (m_tdata[63:0] !== want.digest)
                        flag_mismatch("digest_word", want.digest, m_tdata[63:0]);
                    if (m_tdata[66:64] !== want.idx)
                        flag_mismatch("word_index", 64'(want.idx), 64'(m_tdata[66:64]));
                    if (m_tlast !== want.last)
                        flag_mismatch("last_word", 64'(want.last), 64'(m_tlast));
                end
            end
        end
        pending = digest_q.size();
    end

endmodule

### tb/sv/sha512_hash_tb.sv
`timescale 1ns / 1ps

module sha512_hash_tb;
    import sha512_pkg::*;

    // Longest correct stretch without a transaction is a two-block padding
    // tail plus a full receiver stall; allow many times that.
    localparam int WATCHDOG_LIMIT = 4000;
    // Quiet time after the last digest word, to catch anything stray.
    localparam int DRAIN_CYCLES   = 200;
    localparam int ITEM_TARGET    = 230;
    // Switch idling off for roughly the last this-many items.
    localparam int QUIET_TAIL     = 40;

    logic               clk      = 1'b0;
    logic               rst_n    = 1'b0;
    logic               s_tvalid = 1'b0;
    logic [TDATA_W-1:0] s_tdata  = '0;
    logic               s_tlast  = 1'b0;
    logic               m_tready = 1'b0;
    logic               s_tready;
    logic               m_tvalid;
    logic [TDATA_W-1:0] m_tdata;
    logic               m_tlast;

    int fail_count;
    int pending;
    int words_checked;
    int msgs_closed;
    int items_sent = 0;
    int idle_run   = 0;
    bit gaps_on    = 1'b1;
    int gap_odds   = 4;

    sha512_hash dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    sha512_hash_check checker_inst
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tlast       (s_tlast),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tlast       (m_tlast),
        .fail_count    (fail_count),
        .pending       (pending),
        .words_checked (words_checked),
        .msgs_closed   (msgs_closed)
    );

    always #1 clk = ~clk;

    // Hold reset at the start, then release it once for good.
    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
    end

    // Present one message word and hold it until the transaction completes.
    // An optional idle burst goes in front; valid is only lowered when a gap
    // really follows, so it is never dropped and raised in the same step.
    task automatic send_word(input logic [63:0] wd, input logic [3:0] cnt, input logic fin);
        if (gaps_on && gap_odds != 0 && $urandom_range(0, gap_odds - 1) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {4'd0, cnt, wd};
        s_tlast  <= fin;
        do
            @(posedge clk);
        while (!s_tready);
        items_sent++;
    endtask

    // Send a message of body_words full words and a closing word with the
    // given byte count. Body counts are random: they must be ignored.
    task automatic send_message(input int body_words, input logic [3:0] tail_cnt);
        for (int i = 0; i < body_words; i++)
        begin
            send_word({$urandom, $urandom}, 4'($urandom_range(0, 15)), 1'b0);
        end
        send_word({$urandom, $urandom}, tail_cnt, 1'b1);
    endtask

    // Receiver: alternate ready windows with random stall bursts; stalls stop
    // together with the sender's gaps near the end of the run.
    initial
    begin
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            if (gaps_on && $urandom_range(0, 2) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 17)) @(posedge clk);
            end
            m_tready <= 1'b1;
            repeat ($urandom_range(1, 24)) @(posedge clk);
        end
    end

    // Watchdog: any transaction on either side clears the count of dead cycles.
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
        begin
            idle_run <= 0;
        end
        else if (idle_run >= WATCHDOG_LIMIT)
        begin
            $display("sha512_hash verification failed");
            $finish;
        end
        else
        begin
            idle_run <= idle_run + 1;
        end
    end

    initial
    begin
        int body;
        wait (rst_n);
        @(posedge clk);

        // Directed part.
        // Empty message: count of zero on the only word, content discarded.
        send_word(64'hFFFF_FFFF_FFFF_FFFF, 4'd0, 1'b1);
        // Three bytes of message with set bits beyond them that must be dropped.
        send_word({24'h616263, 40'hFF_FFFF_FFFF}, 4'd3, 1'b1);
        // A full final word of all ones, so the padding takes a word of its own.
        send_word(64'hFFFF_FFFF_FFFF_FFFF, 4'd8, 1'b1);
        // Count above eight reads as eight.
        send_word(64'h0, 4'd15, 1'b1);
        // Short count on a body word is ignored; then an empty tail.
        send_word(64'h0123_4567_89AB_CDEF, 4'd2, 1'b0);
        send_word({$urandom, $urandom}, 4'd0, 1'b1);
        // Fourteen body words and a full tail: padding and length spill into
        // a second block.
        send_message(14, 4'd8);
        // Single-byte and seven-byte tails.
        send_word({$urandom, $urandom}, 4'd1, 1'b1);
        send_word({$urandom, $urandom}, 4'd7, 1'b1);

        // Random part: mostly short messages, some sized around the block
        // boundary so the length words land in one or two blocks, a few long.
        while (items_sent < ITEM_TARGET)
        begin
            if (items_sent >= ITEM_TARGET - QUIET_TAIL)
                gaps_on = 1'b0;
            gap_odds = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(2, 5);
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4: body = $urandom_range(0, 6);
                5, 6, 7:       body = $urandom_range(12, 17);
                8:             body = $urandom_range(28, 33);
                default:       body = $urandom_range(7, 11);
            endcase
            // trim the last message so the run ends near the item target
            if (body > ITEM_TARGET - items_sent - 1)
                body = ITEM_TARGET - items_sent - 1;
            send_message(body, 4'($urandom_range(0, 15)));
        end
        s_tvalid <= 1'b0;
        s_tlast  <= 1'b0;

        // Let the checker see the last transaction, then drain all digests.
        @(posedge clk);
        wait (pending == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Hashed %0d messages from %0d words and checked %0d digest words.",
                 msgs_closed, items_sent, words_checked);
        $display("Run covered empty and partial tails, counts above eight and two-block padding.");
        if (fail_count == 0 && pending == 0)
            $display("sha512_hash verification clean");
        else
            $display("sha512_hash verification failed");
        $finish;
    end

endmodule
